[hw/rtl/rbb_pkg.sv]
// rbb_pkg: shared types, constants and delay functions of the retry backoff breaker
// no dependencies; used by every module of the block by scoped names

package rbb_pkg;

   localparam int TICK_BITS_DEF = 32;

   localparam int FIELD_W    = 32;
   localparam int OP_W       = 3;
   localparam int IDEL_W     = 8;
   localparam int PDEL_W     = 11;
   localparam int QDEL_W     = 11;
   localparam int MOD200_W   = 8;

   localparam int REQ_DATA_W = 160;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register index, taken from paddr[2]
   localparam logic CSR_INVALID_FORMAT = 1'b0;

   localparam logic [FIELD_W-1:0]  STREAK_MAX    = '1;
   localparam logic [IDEL_W-1:0]   REUSE_DELAY   = 8'd10;
   localparam logic [IDEL_W-1:0]   IFACE_BASE    = 8'd10;
   localparam logic [IDEL_W-1:0]   IFACE_CAP     = 8'd160;
   localparam logic [PDEL_W-1:0]   PROG_BASE     = 11'd25;
   localparam logic [PDEL_W-1:0]   PROG_CAP      = 11'd1600;
   localparam logic [QDEL_W-1:0]   QUAR_FLOOR    = 11'd100;
   localparam logic [FIELD_W-1:0]  IFACE_STEPS   = 32'd5;
   localparam logic [FIELD_W-1:0]  PROG_STEPS    = 32'd6;
   localparam logic [FIELD_W-1:0]  IFACE_LOG_MIN = 32'd5;
   localparam logic [FIELD_W-1:0]  PROG_LOG_MIN  = 32'd8;
   localparam logic [FIELD_W-1:0]  QUAR_LOG_MIN  = 32'd6;
   localparam logic [MOD200_W-1:0] IFACE_LOG_MOD = 8'd199;

   typedef enum logic [OP_W-1:0] {
      OP_PROGRAM_QUERY = 3'd0,
      OP_RETRY_EVAL    = 3'd1,
      OP_IFACE_QUERY   = 3'd2,
      OP_CACHE_HIT     = 3'd3,
      OP_REUSE         = 3'd4,
      OP_FAILURE       = 3'd5
   } op_type;

   typedef struct packed {
      logic [OP_W-1:0]    operation;
      logic [FIELD_W-1:0] now_ticks;
      logic [FIELD_W-1:0] program_id;
      logic               pipeline_exists;
      logic [FIELD_W-1:0] color_fmt;
      logic [FIELD_W-1:0] depth_fmt;
      logic [FIELD_W-1:0] stencil_fmt;
   } item_type;

   typedef struct packed {
      logic              verdict;
      logic              skip_build;
      logic [IDEL_W-1:0] interface_delay;
      logic [PDEL_W-1:0] breaker_delay;
      logic [QDEL_W-1:0] blocked_delay;
      logic              log_interface;
      logic              log_program;
      logic              log_blocked;
   } result_type;

   // streak is at least one here
   function automatic logic [IDEL_W-1:0] iface_delay(input logic [FIELD_W-1:0] streak);
      logic [IDEL_W-1:0] d;
      if (streak > IFACE_STEPS) begin
         d = IFACE_CAP;
      end else begin
         d = IFACE_BASE << (streak[2:0] - 3'd1);
      end
      return d;
   endfunction

   function automatic logic [PDEL_W-1:0] prog_delay(input logic [FIELD_W-1:0] streak);
      logic [PDEL_W-1:0] d;
      if (streak > PROG_STEPS) begin
         d = PROG_CAP;
      end else begin
         d = PROG_BASE << (streak[2:0] - 3'd1);
      end
      return d;
   endfunction

   // eight times the interface delay, clamped below; the upper clamp is never reached
   function automatic logic [QDEL_W-1:0] quar_delay(input logic [IDEL_W-1:0] idel);
      logic [QDEL_W-1:0] d;
      if (idel == IFACE_BASE) begin
         d = QUAR_FLOOR;
      end else begin
         d = {idel, 3'b000};
      end
      return d;
   endfunction

endpackage

[hw/rtl/retry_backoff_breaker.sv]
// retry_backoff_breaker: retry throttle with exponential backoff and quarantine
// path: an accepted item passes the input register, then the result register, before rsp_tvalid rises
// throughput: one item per cycle; req_tready drops only while a full pipe meets a stalled rsp
// synchronous active-high reset clears all streaks, deadlines, signatures and the config reg
// depends on rbb_pkg, rbb_csr, rbb_engine

module retry_backoff_breaker #(
   parameter int TICK_BITS = rbb_pkg::TICK_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // now_ticks[31:0], program_id[63:32], color_fmt[95:64], depth_fmt[127:96],
   // stencil_fmt[159:128]
   input  logic [rbb_pkg::REQ_DATA_W-1:0]  req_tdata,
   // operation[2:0], pipeline_exists[3]
   input  logic [rbb_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // verdict[0], skip_build[1], interface_delay[9:2], breaker_delay[20:10],
   // blocked_delay[31:21], log_interface[32], log_program[33], log_blocked[34], zeros
   output logic [rbb_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [rbb_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [rbb_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [rbb_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);

   logic                        in_valid_ff, in_valid_in;
   rbb_pkg::item_type           in_item_ff;
   rbb_pkg::item_type           req_item;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [rbb_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                        advance;
   logic                        req_fire;
   rbb_pkg::result_type         result;
   logic [rbb_pkg::FIELD_W-1:0] invalid_format;

   rbb_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .invalid_format (invalid_format)
   );

   rbb_engine #(
      .TICK_BITS (TICK_BITS)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .fire           (advance),
      .item           (in_item_ff),
      .invalid_format (invalid_format),
      .result         (result)
   );

   assign req_item.operation       = req_tuser[2:0];
   assign req_item.pipeline_exists = req_tuser[3];
   assign req_item.now_ticks       = req_tdata[31:0];
   assign req_item.program_id      = req_tdata[63:32];
   assign req_item.color_fmt       = req_tdata[95:64];
   assign req_item.depth_fmt       = req_tdata[127:96];
   assign req_item.stencil_fmt     = req_tdata[159:128];

   // state updates as the item moves into the result register
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff <= req_item;
      end
      if (advance) begin
         rsp_data_ff <= {5'b00000, result.log_blocked, result.log_program,
                         result.log_interface, result.blocked_delay, result.breaker_delay,
                         result.interface_delay, result.skip_build, result.verdict};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[hw/rtl/rbb_csr.sv]
// rbb_csr: apb-style configuration register holding the invalid format code
// depends on rbb_pkg

module rbb_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [rbb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rbb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rbb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                          csr_pready,
   output logic [rbb_pkg::FIELD_W-1:0]    invalid_format
);

   logic [rbb_pkg::FIELD_W-1:0] invalid_format_ff;
   logic [rbb_pkg::FIELD_W-1:0] invalid_format_in;
   logic                        hit;

   assign hit = (csr_paddr[2] == rbb_pkg::CSR_INVALID_FORMAT);

   always_comb begin
      invalid_format_in = invalid_format_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && hit) begin
         invalid_format_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         invalid_format_ff <= '0;
      end else begin
         invalid_format_ff <= invalid_format_in;
      end
   end

   assign csr_pready     = 1'b1;
   assign csr_prdata     = hit ? invalid_format_ff : '0;
   assign invalid_format = invalid_format_ff;

endmodule

[hw/rtl/rbb_engine.sv]
// rbb_engine: streak, signature and deadline state with the per-item decision logic
// depends on rbb_pkg

module rbb_engine #(
   parameter int TICK_BITS = rbb_pkg::TICK_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  rbb_pkg::item_type           item,
   input  logic [rbb_pkg::FIELD_W-1:0] invalid_format,
   output rbb_pkg::result_type         result
);

   localparam int FW = rbb_pkg::FIELD_W;

   typedef logic [TICK_BITS-1:0] tick_type;

   function automatic tick_type sat_add(input tick_type t,
                                        input logic [rbb_pkg::PDEL_W-1:0] d);
      logic [TICK_BITS:0] s;
      s = {1'b0, t} + {{(TICK_BITS + 1 - rbb_pkg::PDEL_W){1'b0}}, d};
      return s[TICK_BITS] ? '1 : s[TICK_BITS-1:0];
   endfunction

   logic [FW-1:0] sig_program_ff, sig_program_in;
   logic [FW-1:0] sig_color_ff, sig_color_in;
   logic [FW-1:0] sig_depth_ff, sig_depth_in;
   logic [FW-1:0] sig_stencil_ff, sig_stencil_in;
   logic [FW-1:0] sig_streak_ff, sig_streak_in;
   logic [rbb_pkg::MOD200_W-1:0] sig_mod_ff, sig_mod_in;
   tick_type      sig_deadline_ff, sig_deadline_in;
   logic [FW-1:0] breaker_program_ff, breaker_program_in;
   logic [FW-1:0] breaker_streak_ff, breaker_streak_in;
   tick_type      breaker_deadline_ff, breaker_deadline_in;
   logic [FW-1:0] blocked_program_ff, blocked_program_in;
   logic [FW-1:0] blocked_streak_ff, blocked_streak_in;
   tick_type      blocked_deadline_ff, blocked_deadline_in;
   tick_type      retry_deadline_ff, retry_deadline_in;

   logic [TICK_BITS+FW-1:0] now_wide;
   tick_type                now;
   logic                    sig_match;
   logic                    known_prog;
   logic [FW-1:0]           s_streak, b_streak, q_streak;
   logic [rbb_pkg::MOD200_W-1:0] s_mod;
   logic [rbb_pkg::IDEL_W-1:0]   idel;
   logic [rbb_pkg::PDEL_W-1:0]   pdel;
   logic [rbb_pkg::QDEL_W-1:0]   qdel;
   tick_type                s_dl, b_dl, q_dl, reuse_dl;

   // masks or widens the 32-bit time to the counter width
   assign now_wide = {{TICK_BITS{1'b0}}, item.now_ticks};
   assign now      = now_wide[TICK_BITS-1:0];

   assign sig_match = (item.program_id == sig_program_ff) && (item.color_fmt == sig_color_ff) &&
                      (item.depth_fmt == sig_depth_ff) && (item.stencil_fmt == sig_stencil_ff);

   assign known_prog = (item.program_id == sig_program_ff) ||
                       (item.program_id == breaker_program_ff) ||
                       (item.program_id == blocked_program_ff);

   // streaks as they stand after a failure
   always_comb begin
      if (!sig_match) begin
         s_streak = 32'd1;
         s_mod    = 8'd1;
      end else if (sig_streak_ff != rbb_pkg::STREAK_MAX) begin
         s_streak = sig_streak_ff + 32'd1;
         s_mod    = (sig_mod_ff == rbb_pkg::IFACE_LOG_MOD) ? '0 : sig_mod_ff + 8'd1;
      end else begin
         s_streak = sig_streak_ff;
         s_mod    = sig_mod_ff;
      end
      if (breaker_program_ff != item.program_id) begin
         b_streak = 32'd1;
      end else if (breaker_streak_ff != rbb_pkg::STREAK_MAX) begin
         b_streak = breaker_streak_ff + 32'd1;
      end else begin
         b_streak = breaker_streak_ff;
      end
      if (blocked_program_ff != item.program_id) begin
         q_streak = 32'd1;
      end else if (blocked_streak_ff != rbb_pkg::STREAK_MAX) begin
         q_streak = blocked_streak_ff + 32'd1;
      end else begin
         q_streak = blocked_streak_ff;
      end
   end

   assign idel     = rbb_pkg::iface_delay(s_streak);
   assign pdel     = rbb_pkg::prog_delay(b_streak);
   assign qdel     = rbb_pkg::quar_delay(idel);
   assign s_dl     = sat_add(now, {3'b000, idel});
   assign b_dl     = sat_add(now, pdel);
   assign q_dl     = sat_add(now, qdel);
   assign reuse_dl = sat_add(now, {3'b000, rbb_pkg::REUSE_DELAY});

   always_comb begin
      sig_program_in      = sig_program_ff;
      sig_color_in        = sig_color_ff;
      sig_depth_in        = sig_depth_ff;
      sig_stencil_in      = sig_stencil_ff;
      sig_streak_in       = sig_streak_ff;
      sig_mod_in          = sig_mod_ff;
      sig_deadline_in     = sig_deadline_ff;
      breaker_program_in  = breaker_program_ff;
      breaker_streak_in   = breaker_streak_ff;
      breaker_deadline_in = breaker_deadline_ff;
      blocked_program_in  = blocked_program_ff;
      blocked_streak_in   = blocked_streak_ff;
      blocked_deadline_in = blocked_deadline_ff;
      retry_deadline_in   = retry_deadline_ff;
      result              = '0;

      unique case (rbb_pkg::op_type'(item.operation))
         rbb_pkg::OP_PROGRAM_QUERY: begin
            result.verdict = item.pipeline_exists && (item.program_id != '0) &&
                             (item.program_id == breaker_program_ff) &&
                             (now < breaker_deadline_ff);
         end
         rbb_pkg::OP_RETRY_EVAL: begin
            if ((now < retry_deadline_ff) && (item.program_id != '0) && known_prog) begin
               if (item.pipeline_exists) begin
                  result.verdict    = 1'b1;
                  result.skip_build = 1'b1;
               end else begin
                  retry_deadline_in   = '0;
                  breaker_deadline_in = '0;
                  sig_deadline_in     = '0;
               end
            end
         end
         rbb_pkg::OP_IFACE_QUERY: begin
            result.verdict = (now < sig_deadline_ff) && sig_match;
         end
         rbb_pkg::OP_CACHE_HIT: begin
            sig_streak_in   = '0;
            sig_mod_in      = '0;
            sig_program_in  = '0;
            sig_color_in    = invalid_format;
            sig_depth_in    = invalid_format;
            sig_stencil_in  = invalid_format;
            sig_deadline_in = '0;
            if (breaker_program_ff == item.program_id) begin
               breaker_program_in  = '0;
               breaker_deadline_in = '0;
               breaker_streak_in   = '0;
            end
            if (blocked_program_ff == item.program_id) begin
               blocked_program_in  = '0;
               blocked_deadline_in = '0;
               blocked_streak_in   = '0;
            end
         end
         rbb_pkg::OP_REUSE: begin
            sig_program_in    = item.program_id;
            sig_color_in      = item.color_fmt;
            sig_depth_in      = item.depth_fmt;
            sig_stencil_in    = item.stencil_fmt;
            sig_streak_in     = 32'd1;
            sig_mod_in        = 8'd1;
            sig_deadline_in   = reuse_dl;
            retry_deadline_in = reuse_dl;
         end
         rbb_pkg::OP_FAILURE: begin
            sig_program_in      = item.program_id;
            sig_color_in        = item.color_fmt;
            sig_depth_in        = item.depth_fmt;
            sig_stencil_in      = item.stencil_fmt;
            sig_streak_in       = s_streak;
            sig_mod_in          = s_mod;
            sig_deadline_in     = s_dl;
            breaker_program_in  = item.program_id;
            breaker_streak_in   = b_streak;
            breaker_deadline_in = b_dl;
            blocked_program_in  = item.program_id;
            blocked_streak_in   = q_streak;
            blocked_deadline_in = q_dl;
            retry_deadline_in   = (q_dl > s_dl) ? q_dl : s_dl;
            result.interface_delay = idel;
            result.breaker_delay   = pdel;
            result.blocked_delay   = qdel;
            // residue of 200 kept beside the streak; 64 is the low bits
            result.log_interface = (s_streak <= rbb_pkg::IFACE_LOG_MIN) || (s_mod == '0);
            result.log_program   = (b_streak <= rbb_pkg::PROG_LOG_MIN) || (b_streak[5:0] == '0);
            result.log_blocked   = (q_streak <= rbb_pkg::QUAR_LOG_MIN) || (q_streak[5:0] == '0);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sig_program_ff      <= '0;
         sig_color_ff        <= '0;
         sig_depth_ff        <= '0;
         sig_stencil_ff      <= '0;
         sig_streak_ff       <= '0;
         sig_mod_ff          <= '0;
         sig_deadline_ff     <= '0;
         breaker_program_ff  <= '0;
         breaker_streak_ff   <= '0;
         breaker_deadline_ff <= '0;
         blocked_program_ff  <= '0;
         blocked_streak_ff   <= '0;
         blocked_deadline_ff <= '0;
         retry_deadline_ff   <= '0;
      end else if (fire) begin
         sig_program_ff      <= sig_program_in;
         sig_color_ff        <= sig_color_in;
         sig_depth_ff        <= sig_depth_in;
         sig_stencil_ff      <= sig_stencil_in;
         sig_streak_ff       <= sig_streak_in;
         sig_mod_ff          <= sig_mod_in;
         sig_deadline_ff     <= sig_deadline_in;
         breaker_program_ff  <= breaker_program_in;
         breaker_streak_ff   <= breaker_streak_in;
         breaker_deadline_ff <= breaker_deadline_in;
         blocked_program_ff  <= blocked_program_in;
         blocked_streak_ff   <= blocked_streak_in;
         blocked_deadline_ff <= blocked_deadline_in;
         retry_deadline_ff   <= retry_deadline_in;
      end
   end

endmodule

[hw/rtl/rbb_checker.sv]
// rbb_checker: port-level assertions for retry_backoff_breaker, bound to the top level
// depends on rbb_pkg and retry_backoff_breaker

module rbb_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [rbb_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // nothing comes out in the cycle after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // input back-pressure only from a stalled result
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("req_tready low without a stalled result");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   // skip only comes with a positive verdict
   a_skip_verdict: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1]) |-> rsp_tdata[0])
      else $error("skip_build without verdict");

   // a failure result carries all three delays and no verdict
   a_fail_delays: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[9:2] != '0)) |->
         ((rsp_tdata[20:10] != '0) && (rsp_tdata[31:21] != '0) && !rsp_tdata[0]))
      else $error("inconsistent failure delays");

endmodule

bind retry_backoff_breaker rbb_checker u_rbb_checker (.*);

[tb/rbb_result_check.sv]
// rbb_result_check: watches the item, result and csr channels of retry_backoff_breaker,
// keeps its own copy of the throttle state, predicts every result and compares it
// depends on rbb_pkg for the item and result types and the register index

module rbb_result_check (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // now_ticks, program_id, color_fmt, depth_fmt, stencil_fmt
   input  logic [rbb_pkg::REQ_DATA_W-1:0] req_tdata,
   // operation, pipeline_exists
   input  logic [rbb_pkg::REQ_USER_W-1:0] req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // verdict, skip_build, interface_delay, breaker_delay, blocked_delay,
   // log_interface, log_program, log_blocked, zeros
   input  logic [rbb_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic                           csr_pready,
   input  logic [rbb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rbb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output int                             mismatches,
   output int                             outstanding
);
   import rbb_pkg::*;

   localparam logic [31:0] TICK_LIMIT  = 32'hFFFF_FFFF;
   localparam logic [31:0] STREAK_TOP  = 32'hFFFF_FFFF;
   localparam logic [31:0] REUSE_HOLD  = 32'd10;
   localparam logic [7:0]  IFACE_UNIT  = 8'd10;
   localparam logic [10:0] PROG_UNIT   = 11'd25;
   localparam int          IFACE_SHIFT = 4;
   localparam int          PROG_SHIFT  = 6;
   localparam logic [10:0] QUAR_MIN    = 11'd100;
   localparam logic [10:0] QUAR_MAX    = 11'd1500;
   localparam logic [31:0] IFACE_QUIET = 32'd5;
   localparam logic [31:0] PROG_QUIET  = 32'd8;
   localparam logic [31:0] QUAR_QUIET  = 32'd6;
   localparam logic [31:0] IFACE_EVERY = 32'd200;
   localparam logic [31:0] RUN_EVERY   = 32'd64;

   logic [31:0] blank_code;
   logic [31:0] sig_prog, sig_col, sig_dep, sig_ste, sig_run, sig_until;
   logic [31:0] brk_prog, brk_run, brk_until;
   logic [31:0] quar_prog, quar_run, quar_until;
   logic [31:0] retry_until;
   result_type  answers[$];
   int          fault_tally;

   function automatic logic [31:0] add_sat(input logic [31:0] t, input logic [31:0] d);
      logic [32:0] s;
      s = {1'b0, t} + {1'b0, d};
      return s[32] ? TICK_LIMIT : s[31:0];
   endfunction

   function automatic logic [31:0] bump_run(input logic [31:0] s);
      return (s == STREAK_TOP) ? s : s + 32'd1;
   endfunction

   function automatic logic sig_match(input item_type it);
      return it.program_id == sig_prog && it.color_fmt == sig_col &&
             it.depth_fmt == sig_dep && it.stencil_fmt == sig_ste;
   endfunction

   // one item against the throttle state; updates the state and returns the result
   function automatic result_type throttle_step(input item_type it);
      result_type  r;
      logic [31:0] now;
      logic [7:0]  idel;
      logic [10:0] pdel;
      logic [10:0] qdel;
      int          shift;
      r   = '0;
      now = it.now_ticks;
      case (it.operation)
         OP_PROGRAM_QUERY: begin
            r.verdict = it.pipeline_exists && it.program_id != '0 &&
                        it.program_id == brk_prog && now < brk_until;
         end
         OP_RETRY_EVAL: begin
            if (now < retry_until && it.program_id != '0 &&
                (it.program_id == sig_prog || it.program_id == brk_prog ||
                 it.program_id == quar_prog)) begin
               if (it.pipeline_exists) begin
                  r.verdict    = 1'b1;
                  r.skip_build = 1'b1;
               end else begin
                  retry_until = '0;
                  brk_until   = '0;
                  sig_until   = '0;
               end
            end
         end
         OP_IFACE_QUERY: begin
            r.verdict = now < sig_until && sig_match(it);
         end
         OP_CACHE_HIT: begin
            sig_run   = '0;
            sig_prog  = '0;
            sig_col   = blank_code;
            sig_dep   = blank_code;
            sig_ste   = blank_code;
            sig_until = '0;
            if (brk_prog == it.program_id) begin
               brk_prog  = '0;
               brk_until = '0;
               brk_run   = '0;
            end
            if (quar_prog == it.program_id) begin
               quar_prog  = '0;
               quar_until = '0;
               quar_run   = '0;
            end
         end
         OP_REUSE: begin
            sig_prog    = it.program_id;
            sig_col     = it.color_fmt;
            sig_dep     = it.depth_fmt;
            sig_ste     = it.stencil_fmt;
            sig_run     = 32'd1;
            sig_until   = add_sat(now, REUSE_HOLD);
            retry_until = sig_until;
         end
         OP_FAILURE: begin
            if (sig_match(it)) begin
               sig_run = bump_run(sig_run);
            end else begin
               sig_run  = 32'd1;
               sig_prog = it.program_id;
               sig_col  = it.color_fmt;
               sig_dep  = it.depth_fmt;
               sig_ste  = it.stencil_fmt;
            end
            shift     = (sig_run > 32'd5) ? IFACE_SHIFT : int'(sig_run) - 1;
            idel      = IFACE_UNIT << shift;
            sig_until = add_sat(now, {24'd0, idel});

            if (brk_prog == it.program_id) begin
               brk_run = bump_run(brk_run);
            end else begin
               brk_prog = it.program_id;
               brk_run  = 32'd1;
            end
            shift     = (brk_run > 32'd6) ? PROG_SHIFT : int'(brk_run) - 1;
            pdel      = PROG_UNIT << shift;
            brk_until = add_sat(now, {21'd0, pdel});

            if (quar_prog == it.program_id) begin
               quar_run = bump_run(quar_run);
            end else begin
               quar_prog = it.program_id;
               quar_run  = 32'd1;
            end
            qdel = {3'b000, idel} * 11'd8;
            if (qdel < QUAR_MIN) begin
               qdel = QUAR_MIN;
            end
            if (qdel > QUAR_MAX) begin
               qdel = QUAR_MAX;
            end
            quar_until  = add_sat(now, {21'd0, qdel});
            retry_until = (quar_until > sig_until) ? quar_until : sig_until;

            r.interface_delay = idel;
            r.breaker_delay   = pdel;
            r.blocked_delay   = qdel;
            r.log_interface   = sig_run <= IFACE_QUIET || sig_run % IFACE_EVERY == '0;
            r.log_program     = brk_run <= PROG_QUIET || brk_run % RUN_EVERY == '0;
            r.log_blocked     = quar_run <= QUAR_QUIET || quar_run % RUN_EVERY == '0;
         end
         default: begin
            // spare codes leave everything alone
         end
      endcase
      return r;
   endfunction

   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         fault_tally++;
         $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      item_type   it;
      result_type got;
      result_type want;
      if (reset) begin
         blank_code  = '0;
         sig_prog    = '0;
         sig_col     = '0;
         sig_dep     = '0;
         sig_ste     = '0;
         sig_run     = '0;
         sig_until   = '0;
         brk_prog    = '0;
         brk_run     = '0;
         brk_until   = '0;
         quar_prog   = '0;
         quar_run    = '0;
         quar_until  = '0;
         retry_until = '0;
         answers.delete();
         fault_tally = 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
             csr_paddr[2] == CSR_INVALID_FORMAT) begin
            blank_code = csr_pwdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '0;
            got.verdict         = rsp_tdata[0];
            got.skip_build      = rsp_tdata[1];
            got.interface_delay = rsp_tdata[9:2];
            got.breaker_delay   = rsp_tdata[20:10];
            got.blocked_delay   = rsp_tdata[31:21];
            got.log_interface   = rsp_tdata[32];
            got.log_program     = rsp_tdata[33];
            got.log_blocked     = rsp_tdata[34];
            if (answers.size() == 0) begin
               fault_tally++;
               $display("%0t: no result expected, got %h", $time, rsp_tdata);
            end else begin
               want = answers.pop_front();
               check_field("verdict", 32'(want.verdict), 32'(got.verdict));
               check_field("skip_build", 32'(want.skip_build), 32'(got.skip_build));
               check_field("interface_delay", 32'(want.interface_delay),
                           32'(got.interface_delay));
               check_field("breaker_delay", 32'(want.breaker_delay),
                           32'(got.breaker_delay));
               check_field("blocked_delay", 32'(want.blocked_delay),
                           32'(got.blocked_delay));
               check_field("log_interface", 32'(want.log_interface),
                           32'(got.log_interface));
               check_field("log_program", 32'(want.log_program), 32'(got.log_program));
               check_field("log_blocked", 32'(want.log_blocked),
                           32'(got.log_blocked));
            end
         end
         if (req_tvalid && req_tready) begin
            it.operation       = req_tuser[2:0];
            it.pipeline_exists = req_tuser[3];
            it.now_ticks       = req_tdata[31:0];
            it.program_id      = req_tdata[63:32];
            it.color_fmt       = req_tdata[95:64];
            it.depth_fmt       = req_tdata[127:96];
            it.stencil_fmt     = req_tdata[159:128];
            answers.push_back(throttle_step(it));
         end
      end
      mismatches  <= fault_tally;
      outstanding <= answers.size();
   end

endmodule

[tb/retry_backoff_breaker_test.sv]
// retry_backoff_breaker_test: drives items, stalls and format register writes into
// retry_backoff_breaker and gives the verdict from the counts of rbb_result_check
// depends on rbb_pkg, retry_backoff_breaker and rbb_result_check

module retry_backoff_breaker_test;
   import rbb_pkg::*;

   localparam logic [OP_W-1:0]       OP_SPARE_LOW  = 3'd6;
   localparam logic [OP_W-1:0]       OP_SPARE_HIGH = 3'd7;
   localparam logic [CSR_ADDR_W-1:0] FORMAT_ADDR   = {CSR_INVALID_FORMAT, 2'b00};
   localparam logic [31:0]           ALL_ONES      = 32'hFFFF_FFFF;
   localparam int                    DRAIN_LIMIT   = 2000;
   localparam int                    SETTLE        = 8;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   // now_ticks[31:0], program_id[63:32], color_fmt[95:64], depth_fmt[127:96],
   // stencil_fmt[159:128]
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   // operation[2:0], pipeline_exists[3]
   logic [REQ_USER_W-1:0] req_tuser   = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   // verdict[0], skip_build[1], interface_delay[9:2], breaker_delay[20:10],
   // blocked_delay[31:21], log_interface[32], log_program[33], log_blocked[34]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int          mismatches;
   int          outstanding;
   bit          steady = 1'b0;
   int          sent = 0;
   logic [31:0] wall = '0;
   logic [31:0] blank_fmt = '0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   retry_backoff_breaker u_top (.*);

   rbb_result_check u_result_check (.*);

   task automatic issue(input logic [OP_W-1:0] op, input logic [31:0] now, prog,
                        input logic exists, input logic [31:0] col, dep, ste);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ste, dep, col, prog, now};
      req_tuser  <= {exists, op};
      do @(posedge clock); while (!req_tready);
      sent++;
      if ($urandom_range(0, 39) == 0) begin
         steady = !steady;
      end
   endtask

   task automatic write_format(input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= FORMAT_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      blank_fmt = value;
   endtask

   task automatic drain();
      int waited;
      req_tvalid <= 1'b0;
      @(posedge clock);
      waited = 0;
      while (outstanding != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_prog();
      case ($urandom_range(0, 6))
         0:       return '0;
         1:       return ALL_ONES;
         2:       return $urandom;
         default: return $urandom_range(1, 3);
      endcase
   endfunction

   function automatic logic [31:0] pick_fmt();
      case ($urandom_range(0, 4))
         0:       return blank_fmt;
         1:       return $urandom;
         default: return $urandom_range(40, 43);
      endcase
   endfunction

   task automatic advance_wall();
      case ($urandom_range(0, 19))
         0:       wall = ALL_ONES - $urandom_range(0, 3000);  // close to the counter top
         1:       wall = $urandom;
         2, 3:    wall = wall + $urandom_range(100, 2500);    // let deadlines lapse
         default: wall = wall + $urandom_range(0, 60);
      endcase
   endtask

   // a query or a state change around the current failure signature
   task automatic probe(input logic [31:0] prog, col, dep, ste, input bit keep_runs);
      logic [OP_W-1:0] op;
      logic [31:0]     now;
      now = wall + $urandom_range(0, 1700);
      case (keep_runs ? $urandom_range(0, 7) : $urandom_range(0, 9))
         0, 1, 2: op = OP_PROGRAM_QUERY;
         3, 4, 5: op = OP_RETRY_EVAL;
         6, 7:    op = OP_IFACE_QUERY;
         8:       op = OP_CACHE_HIT;
         default: op = OP_REUSE;
      endcase
      // now and then one field of the signature is off
      case ($urandom_range(0, 7))
         0:       prog = pick_prog();
         1:       col = pick_fmt();
         2:       dep = $urandom;
         3:       ste = pick_fmt();
         default: ;
      endcase
      issue(op, now, prog, 1'($urandom_range(0, 1)), col, dep, ste);
   endtask

   task automatic random_round();
      logic [31:0] prog, col, dep, ste;
      if ($urandom_range(0, 9) < 7) begin
         prog = pick_prog();
         col  = pick_fmt();
         dep  = pick_fmt();
         ste  = pick_fmt();
         repeat ($urandom_range(1, 10)) begin
            advance_wall();
            issue(OP_FAILURE, wall, prog, 1'($urandom_range(0, 1)), col, dep, ste);
            repeat ($urandom_range(0, 3)) probe(prog, col, dep, ste, 1'b0);
         end
      end else begin
         repeat ($urandom_range(1, 4)) begin
            issue(3'($urandom_range(0, 7)), $urandom, $urandom, 1'($urandom_range(0, 1)),
                  $urandom, $urandom, $urandom);
         end
      end
   endtask

   initial begin : stimulus
      logic [31:0] prog, col, dep, ste;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_format($urandom);
      // nothing armed yet
      issue(OP_PROGRAM_QUERY, '0, '0, 1'b0, '0, '0, '0);
      issue(OP_RETRY_EVAL, '0, 32'd5, 1'b1, '0, '0, '0);
      issue(OP_IFACE_QUERY, '0, '0, 1'b0, '0, '0, '0);
      // first failure arms every deadline
      issue(OP_FAILURE, 32'd100, 32'd5, 1'b1, 32'd40, 32'd41, 32'd42);
      issue(OP_IFACE_QUERY, 32'd105, 32'd5, 1'b0, 32'd40, 32'd41, 32'd42);
      issue(OP_PROGRAM_QUERY, 32'd110, 32'd5, 1'b1, 32'd40, 32'd41, 32'd42);
      issue(OP_RETRY_EVAL, 32'd120, 32'd5, 1'b1, 32'd40, 32'd41, 32'd42);
      // no pipeline present: the retry clears the retry, breaker and interface deadlines
      issue(OP_RETRY_EVAL, 32'd120, 32'd5, 1'b0, 32'd40, 32'd41, 32'd42);
      issue(OP_PROGRAM_QUERY, 32'd121, 32'd5, 1'b1, 32'd40, 32'd41, 32'd42);
      // streak up to where both delays cap
      repeat (6) issue(OP_FAILURE, 32'd200, 32'd5, 1'b0, 32'd40, 32'd41, 32'd42);
      // program id zero
      issue(OP_FAILURE, 32'd300, '0, 1'b1, 32'd40, 32'd41, 32'd42);
      issue(OP_PROGRAM_QUERY, 32'd301, '0, 1'b1, 32'd40, 32'd41, 32'd42);
      issue(OP_RETRY_EVAL, 32'd301, '0, 1'b1, 32'd40, 32'd41, 32'd42);
      issue(OP_CACHE_HIT, 32'd302, '0, 1'b0, 32'd40, 32'd41, 32'd42);
      // deadlines saturate at the counter top
      issue(OP_REUSE, ALL_ONES - 32'd4, 32'd7, 1'b1, blank_fmt, blank_fmt, blank_fmt);
      issue(OP_IFACE_QUERY, ALL_ONES - 32'd1, 32'd7, 1'b0, blank_fmt, blank_fmt, blank_fmt);
      issue(OP_FAILURE, ALL_ONES, ALL_ONES, 1'b1, ALL_ONES, ALL_ONES, ALL_ONES);
      issue(OP_SPARE_LOW, ALL_ONES, ALL_ONES, 1'b1, ALL_ONES, ALL_ONES, ALL_ONES);
      issue(OP_SPARE_HIGH, ALL_ONES, ALL_ONES, 1'b1, ALL_ONES, ALL_ONES, ALL_ONES);
      issue(OP_CACHE_HIT, ALL_ONES, ALL_ONES, 1'b1, ALL_ONES, ALL_ONES, ALL_ONES);
      issue(OP_IFACE_QUERY, '0, '0, 1'b0, blank_fmt, blank_fmt, blank_fmt);
      drain();

      // one long run of failures so that the streaks pass 64, 128, 192 and 200
      write_format('0);
      prog = $urandom_range(1, 3);
      col  = pick_fmt();
      dep  = pick_fmt();
      ste  = pick_fmt();
      repeat (201) begin
         advance_wall();
         issue(OP_FAILURE, wall, prog, 1'($urandom_range(0, 1)), col, dep, ste);
         if ($urandom_range(0, 3) == 0) begin
            probe(prog, col, dep, ste, 1'b1);
         end
      end
      while (sent < 380) random_round();
      drain();

      write_format(ALL_ONES);
      while (sent < 600) random_round();
      drain();

      write_format($urandom);
      while (sent < 820) random_round();
      drain();

      if (mismatches == 0 && outstanding == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin : result_sink
      int hold;
      @(posedge clock);
      forever begin
         hold = steady ? 0 : $urandom_range(0, 5);
         if (hold != 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   initial begin : watchdog
      #400000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
